// ===== hw/rtl/command_line_tokenizer_core_assert.svh =====
// Assertion helpers shared by the tokenizer modules.
`ifndef COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLTOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/cltok_pkg.sv =====
package cltok_pkg;

   // Parser phases.
   localparam logic [2:0] PH_START       = 3'd0;
   localparam logic [2:0] PH_PROG_QUOTED = 3'd1;
   localparam logic [2:0] PH_PROG_PLAIN  = 3'd2;
   localparam logic [2:0] PH_GAP         = 3'd3;
   localparam logic [2:0] PH_ARG         = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_ARG  = 2'd1;
   localparam logic [1:0] KIND_LINE = 2'd2;

   // Special code units.
   localparam logic [15:0] CH_QUOTE  = 16'h0022;
   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_TAB    = 16'h0009;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_NUL    = 16'h0000;

   // At most three results follow from one code unit.
   localparam int RES_SLOTS = 3;
   localparam int SLOT_W    = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] out_char;
      logic [7:0]  repeat_res;
      logic [15:0] arg_count;
      logic [15:0] byte_count;
   } res_type;

   typedef res_type [RES_SLOTS-1:0] res_list_type;

   // Line context, apart from the backslash run.
   typedef struct packed {
      logic [2:0]  phase;
      logic        in_quotes;
      logic        quote_pending;
      logic [15:0] arg_total;
      logic [15:0] byte_total;
   } ctx_type;

   // Load request into the result buffer.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] count;
   } load_type;

endpackage

// ===== hw/rtl/cltok_step.sv =====
module cltok_step #(
   parameter int MAX_BACKSLASH_RUN = 255,
   localparam int RunW = $clog2(MAX_BACKSLASH_RUN + 1)
) (
   input  logic [15:0]                code_unit,
   input  logic [1:0]                 bytes_per_char,
   input  cltok_pkg::ctx_type         ctx,
   input  logic [RunW-1:0]            bs_run,
   output cltok_pkg::ctx_type         ctx_next,
   output logic [RunW-1:0]            bs_next,
   output cltok_pkg::res_list_type    res,
   output logic [cltok_pkg::SLOT_W-1:0] res_count,
   output logic                       line_end
);
   import cltok_pkg::*;

   localparam logic [RunW-1:0] RunMax = RunW'(MAX_BACKSLASH_RUN);
   localparam logic [RunW+7:0] ClampMax = (RunW + 8)'(255);

   logic            is_q, is_bs, is_zero, is_blank;
   logic            au_do, au_inq;
   logic [RunW-1:0] au_n;
   logic [RunW+7:0] run_wide, run_sel;
   logic [7:0]      flush_len;
   logic            f_char, f_end, f_line;
   logic [15:0]     ch_val;
   logic [8:0]      units;
   logic [10:0]     add_bytes;
   logic [16:0]     byte_sum;
   logic [15:0]     byte_new, arg_new;
   res_type         cand [4];
   logic [3:0]      cand_v;
   logic [SLOT_W-1:0] cnt;

   assign is_q     = code_unit == CH_QUOTE;
   assign is_bs    = code_unit == CH_BSLASH;
   assign is_zero  = code_unit == CH_NUL;
   assign is_blank = (code_unit == CH_SPACE) || (code_unit == CH_TAB);

   // Phase decode, then the argument rules for code units inside arguments.
   always_comb begin
      ctx_next  = ctx;
      bs_next   = bs_run;
      au_do     = 1'b0;
      au_inq    = ctx.in_quotes;
      au_n      = bs_run;
      run_sel   = '0;
      f_char    = 1'b0;
      f_end     = 1'b0;
      f_line    = 1'b0;
      ch_val    = code_unit;
      run_wide  = (RunW + 8)'(au_n);

      unique case (ctx.phase)
         PH_START: begin
            if (is_q) begin
               ctx_next.phase = PH_PROG_QUOTED;
            end else if (is_zero) begin
               f_end  = 1'b1;
               f_line = 1'b1;
            end else if (is_blank) begin
               f_end          = 1'b1;
               ctx_next.phase = PH_GAP;
            end else begin
               f_char         = 1'b1;
               ctx_next.phase = PH_PROG_PLAIN;
            end
         end
         PH_PROG_QUOTED: begin
            if (is_zero) begin
               f_end  = 1'b1;
               f_line = 1'b1;
            end else if (is_q) begin
               f_end          = 1'b1;
               ctx_next.phase = PH_GAP;
            end else begin
               f_char = 1'b1;
            end
         end
         PH_PROG_PLAIN: begin
            if (is_zero) begin
               f_end  = 1'b1;
               f_line = 1'b1;
            end else if (is_blank) begin
               f_end          = 1'b1;
               ctx_next.phase = PH_GAP;
            end else begin
               f_char = 1'b1;
            end
         end
         PH_GAP: begin
            if (is_zero) begin
               f_line = 1'b1;
            end else if (!is_blank) begin
               ctx_next.phase         = PH_ARG;
               ctx_next.in_quotes     = 1'b0;
               ctx_next.quote_pending = 1'b0;
               au_do  = 1'b1;
               au_inq = 1'b0;
               au_n   = '0;
            end
         end
         PH_ARG: begin
            if (ctx.quote_pending) begin
               ctx_next.quote_pending = 1'b0;
               ctx_next.in_quotes     = 1'b0;
               if (is_q) begin
                  f_char = 1'b1;
               end else begin
                  au_do  = 1'b1;
                  au_inq = 1'b0;
               end
            end else begin
               au_do = 1'b1;
            end
         end
         default: begin
            ctx_next = '0;
            bs_next  = '0;
         end
      endcase

      // Argument rules: backslash runs, quotes, separators.
      run_wide = (RunW + 8)'(au_n);
      if (au_do) begin
         if (is_bs) begin
            bs_next = (au_n < RunMax) ? au_n + RunW'(1) : au_n;
         end else begin
            bs_next = '0;
            if (is_q) begin
               run_sel = run_wide >> 1;
               if (au_n[0]) begin
                  f_char = 1'b1;
               end else if (au_inq) begin
                  ctx_next.quote_pending = 1'b1;
               end else begin
                  ctx_next.in_quotes = 1'b1;
               end
            end else begin
               run_sel = run_wide;
               if (is_zero) begin
                  f_end  = 1'b1;
                  f_line = 1'b1;
               end else if (!au_inq && is_blank) begin
                  f_end          = 1'b1;
                  ctx_next.phase = PH_GAP;
               end else begin
                  f_char = 1'b1;
               end
            end
         end
      end
      flush_len = (run_sel > ClampMax) ? 8'd255 : run_sel[7:0];

      // Counters: sequential saturating adds collapse into one saturating add.
      units     = 9'(flush_len) + 9'(f_char) + 9'(f_end);
      add_bytes = 11'(units) * 11'(bytes_per_char);
      byte_sum  = 17'(ctx.byte_total) + 17'(add_bytes);
      byte_new  = byte_sum[16] ? 16'hFFFF : byte_sum[15:0];
      arg_new   = (f_end && (ctx.arg_total != 16'hFFFF)) ?
                  ctx.arg_total + 16'd1 : ctx.arg_total;

      if (au_do || !(ctx.phase > PH_ARG)) begin
         ctx_next.byte_total = byte_new;
         ctx_next.arg_total  = arg_new;
      end
      if (f_line) begin
         ctx_next = '0;
         bs_next  = '0;
      end
   end

   // Candidate results in emission order.
   always_comb begin
      cand[0] = '{kind: KIND_CHAR, out_char: CH_BSLASH, repeat_res: flush_len,
                  arg_count: 16'd0, byte_count: 16'd0};
      cand[1] = '{kind: KIND_CHAR, out_char: ch_val, repeat_res: 8'd1,
                  arg_count: 16'd0, byte_count: 16'd0};
      cand[2] = '{kind: KIND_ARG, out_char: 16'd0, repeat_res: 8'd0,
                  arg_count: 16'd0, byte_count: 16'd0};
      cand[3] = '{kind: KIND_LINE, out_char: 16'd0, repeat_res: 8'd0,
                  arg_count: arg_new, byte_count: byte_new};
      cand_v  = {f_line, f_end, f_char, flush_len != 8'd0};
   end

   // Pack the active candidates into consecutive slots.
   always_comb begin
      res = '0;
      cnt = '0;
      for (int k = 0; k < 4; k++) begin
         if (cand_v[k] && (cnt < SLOT_W'(RES_SLOTS))) begin
            res[cnt] = cand[k];
            cnt      = cnt + SLOT_W'(1);
         end
      end
   end

   assign res_count = cnt;
   assign line_end  = f_line;

endmodule

// ===== hw/rtl/cltok_outbuf.sv =====
module cltok_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  cltok_pkg::load_type     load,
   input  cltok_pkg::res_list_type load_res,
   input  logic                    out_ready,
   output logic                    out_valid,
   output logic                    out_last,
   output cltok_pkg::res_type      out_res,
   output logic                    free
);
   import cltok_pkg::*;

   res_list_type      res_ff, res_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              take;

   // Present the slot under the read index.
   assign out_valid = cnt_ff != '0;
   assign out_last  = idx_ff == (cnt_ff - SLOT_W'(1));
   assign out_res   = res_ff[idx_ff];
   assign take      = out_valid && out_ready;
   assign free      = !out_valid || (out_ready && out_last);

   // A load replaces the buffer; otherwise each beat advances the index, and the last beat empties the buffer.
   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load.valid) begin
         res_in = load_res;
         cnt_in = load.count;
         idx_in = '0;
      end else if (take) begin
         if (out_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

`include "command_line_tokenizer_core_assert.svh"
   `CLTOK_ASSERT_NOW(a_load_when_free, clock, reset, load.valid, free, "load while busy")
   `CLTOK_ASSERT_NOW(a_idx_in_range, clock, reset, out_valid, idx_ff < cnt_ff, "index range")
   `CLTOK_ASSERT_NEXT(a_step_idx, clock, reset, take && !out_last && !load.valid, idx_ff == $past(idx_ff) + SLOT_W'(1), "index step")

endmodule

// ===== hw/rtl/command_line_tokenizer_core.sv =====
// Channel   Ports                        Beat
// --------  ---------------------------  ------------------------------------
// request   req_valid/req_ready          one code unit of the command line
// response  rsp_valid/rsp_ready          one result, rsp_last on the final one
// csr       csr_valid/csr_ready          bytes_per_char write, always ready
//
// One code unit enters per cycle while the result buffer is free; it is held in the
// input register and then decoded into the result buffer. Each code unit gives
// zero to three results, delivered one per cycle while rsp_ready is high; the next
// code unit is decoded only as the last result of the previous one leaves.
// A stalled response holds the buffer; one more code unit waits in the input
// register. Reset clears the line state and sets bytes_per_char to one.
module command_line_tokenizer_core #(
   parameter int MAX_BACKSLASH_RUN = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_char,
   output logic [7:0]  rsp_repeat_res,
   output logic [15:0] rsp_arg_count,
   output logic [15:0] rsp_byte_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_bytes_per_char
);
   import cltok_pkg::*;

   localparam int RunW = $clog2(MAX_BACKSLASH_RUN + 1);

   logic              in_valid_ff, in_valid_in;
   logic [15:0]       in_char_ff, in_char_in;
   logic [1:0]        bpc_ff, bpc_in;
   ctx_type           ctx_ff, ctx_in, ctx_next;
   logic [RunW-1:0]   bs_ff, bs_in, bs_next;
   res_list_type      step_res;
   logic [SLOT_W-1:0] step_cnt;
   logic              step_line;
   load_type          load;
   res_type           out_res;
   logic              buf_free;
   logic              advance;

   // Input register: refills whenever it is empty or the held code unit moves on.
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_code_unit;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Line state moves only when a code unit is decoded.
   always_comb begin
      ctx_in = advance ? ctx_next : ctx_ff;
      bs_in  = advance ? bs_next : bs_ff;
      bpc_in = (csr_valid && csr_ready) ? csr_bytes_per_char : bpc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ctx_ff      <= '0;
         bs_ff       <= '0;
         bpc_ff      <= 2'd1;
      end else begin
         in_valid_ff <= in_valid_in;
         ctx_ff      <= ctx_in;
         bs_ff       <= bs_in;
         bpc_ff      <= bpc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   cltok_step #(
      .MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN)
   ) u_step (
      .code_unit      (in_char_ff),
      .bytes_per_char (bpc_ff),
      .ctx            (ctx_ff),
      .bs_run         (bs_ff),
      .ctx_next       (ctx_next),
      .bs_next        (bs_next),
      .res            (step_res),
      .res_count      (step_cnt),
      .line_end       (step_line)
   );

   // Every decoded code unit reloads the buffer, with zero results if none.
   assign load.valid = advance;
   assign load.count = step_cnt;

   cltok_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_res  (step_res),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_last  (rsp_last),
      .out_res   (out_res),
      .free      (buf_free)
   );

   assign rsp_kind       = out_res.kind;
   assign rsp_out_char   = out_res.out_char;
   assign rsp_repeat_res = out_res.repeat_res;
   assign rsp_arg_count  = out_res.arg_count;
   assign rsp_byte_count = out_res.byte_count;

`include "command_line_tokenizer_core_assert.svh"
   `CLTOK_ASSERT_NOW(a_line_is_last, clock, reset, rsp_valid && (rsp_kind == KIND_LINE), rsp_last, "end of line not last")
   `CLTOK_ASSERT_NEXT(a_line_clears, clock, reset, advance && step_line, (ctx_ff == '0) && (bs_ff == '0), "line state not cleared")
   `CLTOK_ASSERT_NOW(a_stall_holds, clock, reset, !req_ready, in_valid_ff && !buf_free, "request stalled without cause")

endmodule

// ===== tb/sv/tb_command_line_tokenizer_core.sv =====
module tb_command_line_tokenizer_core;
   import cltok_pkg::*;

   localparam int SLASH_RUN_CAP = 255;
   localparam int COUNT_CAP = 65535;
   localparam int CYCLE_LIMIT = 50_000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int TAIL_CYCLES = 8;
   localparam int IDLE_PERCENT = 22;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] out_char;
      logic [7:0]  repeat_res;
      logic [15:0] arg_count;
      logic [15:0] byte_count;
      logic        last;
   } token_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_out_char;
   logic [7:0]  rsp_repeat_res;
   logic [15:0] rsp_arg_count;
   logic [15:0] rsp_byte_count;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_bytes_per_char = 2'd1;

   // Pacing controls, each written by the sequencing block only.
   logic        idle_on = 1'b1;
   int          hold_asks = 0;

   // Pending code units and the expected token beats.
   logic [15:0] code_units [$];
   token_beat_type awaited [$];
   int          units_planned = 0;
   int          units_sent = 0;
   int          results_checked = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   token_beat_type want;

   // Tokenizer state as the predictor tracks it.
   logic [2:0]  line_phase;
   logic        quoting;
   logic        quote_held;
   int          slash_run;
   int          args_seen;
   int          bytes_seen;
   int          unit_bytes;

   // Opening lines: empty program names, a quoted program cut off by the
   // terminator, tab separation, all-ones code unit, backslash runs of both
   // parities before quotes, a doubled quote, a quote held open across a
   // separator and a trailing backslash flushed at end of line.
   logic [15:0] opening_units [33] = '{
      CH_NUL,
      CH_SPACE, CH_NUL,
      CH_QUOTE, CH_NUL,
      16'hFFFF, CH_TAB, CH_QUOTE, CH_QUOTE, CH_NUL,
      CH_QUOTE, 16'h0070, CH_QUOTE, 16'h0061, CH_BSLASH, CH_BSLASH, CH_QUOTE,
      16'h0062, CH_SPACE, 16'h0063, CH_QUOTE, CH_QUOTE, CH_QUOTE, 16'h0064,
      CH_QUOTE, CH_TAB, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_QUOTE, CH_SPACE,
      CH_BSLASH, CH_NUL
   };

   command_line_tokenizer_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_unit      (req_code_unit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_char       (rsp_out_char),
      .rsp_repeat_res     (rsp_repeat_res),
      .rsp_arg_count      (rsp_arg_count),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_bytes_per_char (csr_bytes_per_char)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predictor helpers.
   function void restart_line();
      line_phase = PH_START;
      quoting = 1'b0;
      quote_held = 1'b0;
      slash_run = 0;
      args_seen = 0;
      bytes_seen = 0;
   endfunction

   function void put_result(logic [1:0] kind, logic [15:0] ch, logic [7:0] rep,
                            logic [15:0] ac, logic [15:0] bc);
      token_beat_type beat;
      beat.kind = kind;
      beat.out_char = ch;
      beat.repeat_res = rep;
      beat.arg_count = ac;
      beat.byte_count = bc;
      beat.last = 1'b0;
      awaited.push_back(beat);
   endfunction

   function void count_bytes(int n);
      int sum;
      sum = bytes_seen + n * unit_bytes;
      bytes_seen = (sum > COUNT_CAP) ? COUNT_CAP : sum;
   endfunction

   function void put_char(logic [15:0] ch);
      put_result(KIND_CHAR, ch, 8'd1, 16'd0, 16'd0);
      count_bytes(1);
   endfunction

   // A backslash run goes out as one beat, clamped to the repeat width.
   function void put_backslashes(int n);
      int len;
      len = (n > 255) ? 255 : n;
      if (len != 0) begin
         put_result(KIND_CHAR, CH_BSLASH, 8'(len), 16'd0, 16'd0);
         count_bytes(len);
      end
   endfunction

   function void close_argument();
      put_result(KIND_ARG, 16'd0, 8'd0, 16'd0, 16'd0);
      if (args_seen < COUNT_CAP) args_seen++;
      count_bytes(1);
   endfunction

   function void close_line();
      put_result(KIND_LINE, 16'd0, 8'd0, 16'(args_seen), 16'(bytes_seen));
      restart_line();
   endfunction

   function logic is_blank(logic [15:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   // One code unit inside a later argument, with backslash-quote rules.
   function void scan_arg_unit(logic [15:0] c);
      int run;
      run = slash_run;
      if (c == CH_BSLASH) begin
         if (slash_run < SLASH_RUN_CAP) slash_run++;
         return;
      end
      slash_run = 0;
      if (c == CH_QUOTE) begin
         put_backslashes(run / 2);
         if (run % 2 == 1) put_char(CH_QUOTE);
         else if (quoting) quote_held = 1'b1;
         else quoting = 1'b1;
         return;
      end
      put_backslashes(run);
      if (c == CH_NUL) begin
         close_argument();
         close_line();
      end else if (!quoting && is_blank(c)) begin
         close_argument();
         line_phase = PH_GAP;
      end else begin
         put_char(c);
      end
   endfunction

   // Expected token beats for one accepted code unit.
   function void predict_unit(logic [15:0] c);
      int first;
      first = awaited.size();
      case (line_phase)
         PH_START: begin
            if (c == CH_QUOTE) begin
               line_phase = PH_PROG_QUOTED;
            end else if (c == CH_NUL) begin
               close_argument();
               close_line();
            end else if (is_blank(c)) begin
               close_argument();
               line_phase = PH_GAP;
            end else begin
               put_char(c);
               line_phase = PH_PROG_PLAIN;
            end
         end
         PH_PROG_QUOTED: begin
            if (c == CH_NUL) begin
               close_argument();
               close_line();
            end else if (c == CH_QUOTE) begin
               close_argument();
               line_phase = PH_GAP;
            end else begin
               put_char(c);
            end
         end
         PH_PROG_PLAIN: begin
            if (c == CH_NUL) begin
               close_argument();
               close_line();
            end else if (is_blank(c)) begin
               close_argument();
               line_phase = PH_GAP;
            end else begin
               put_char(c);
            end
         end
         PH_GAP: begin
            if (c == CH_NUL) begin
               close_line();
            end else if (!is_blank(c)) begin
               line_phase = PH_ARG;
               quoting = 1'b0;
               quote_held = 1'b0;
               slash_run = 0;
               scan_arg_unit(c);
            end
         end
         PH_ARG: begin
            if (quote_held) begin
               quote_held = 1'b0;
               quoting = 1'b0;
               if (c == CH_QUOTE) put_char(CH_QUOTE);
               else scan_arg_unit(c);
            end else begin
               scan_arg_unit(c);
            end
         end
         default: begin
            restart_line();
         end
      endcase
      if (awaited.size() > first) awaited[awaited.size() - 1].last = 1'b1;
   endfunction

   // Stimulus builders.
   function void queue_unit(logic [15:0] c);
      code_units.push_back(c);
      units_planned++;
   endfunction

   function void queue_slashes(int n);
      repeat (n) queue_unit(CH_BSLASH);
   endfunction

   function logic [15:0] plain_unit();
      logic [15:0] c;
      do begin
         c = 16'($urandom_range(1, 16'hFFFF));
      end while (c == CH_QUOTE || c == CH_BSLASH || is_blank(c));
      return c;
   endfunction

   function logic [15:0] blank_unit();
      return ($urandom_range(1) == 0) ? CH_SPACE : CH_TAB;
   endfunction

   function logic [15:0] any_unit();
      int r;
      r = $urandom_range(99);
      if (r < 15) return CH_QUOTE;
      else if (r < 30) return CH_BSLASH;
      else if (r < 42) return CH_SPACE;
      else if (r < 50) return CH_TAB;
      else if (r < 53) return CH_NUL;
      else if (r < 85) return plain_unit();
      else return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // A well-formed line: program name, a few arguments, terminator.
   function void build_line();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         queue_unit(blank_unit());
      end else if (pick < 5) begin
         queue_unit(CH_QUOTE);
         repeat ($urandom_range(4))
            queue_unit(($urandom_range(3) == 0) ? blank_unit() : plain_unit());
         if ($urandom_range(7) != 0) queue_unit(CH_QUOTE);
      end else begin
         queue_unit(plain_unit());
         repeat ($urandom_range(4)) begin
            case ($urandom_range(5))
               0: queue_unit(CH_BSLASH);
               1: queue_unit(CH_QUOTE);
               default: queue_unit(plain_unit());
            endcase
         end
      end
      repeat ($urandom_range(4)) begin
         repeat ($urandom_range(1, 2)) queue_unit(blank_unit());
         repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(5))
               0: queue_unit(plain_unit());
               1: begin
                  queue_slashes($urandom_range(1, 5));
                  queue_unit(CH_QUOTE);
               end
               2: begin
                  queue_slashes($urandom_range(1, 4));
                  queue_unit(plain_unit());
               end
               3: queue_unit(CH_QUOTE);
               4: begin
                  queue_unit(CH_QUOTE);
                  queue_unit(CH_QUOTE);
               end
               default: queue_unit(blank_unit());
            endcase
         end
      end
      if ($urandom_range(2) == 0) queue_unit(blank_unit());
      queue_unit(CH_NUL);
   endfunction

   // Mostly well-formed lines, one in five is noise.
   function void fill_random(int target);
      int start;
      start = units_planned;
      while (units_planned - start < target) begin
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(2, 10)) queue_unit(any_unit());
            queue_unit(CH_NUL);
         end else begin
            build_line();
         end
      end
   endfunction

   function void check_field(string name, int unsigned expected, int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatches++;
      end
   endfunction

   // Wait until every code unit is in and every beat is out, plus a tail.
   task settle();
      while (!(units_sent == units_planned && awaited.size() == 0)) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task set_bytes_per_char(input logic [1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_bytes_per_char <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unit_bytes = value;
   endtask

   // Request driver: one code unit per beat, random gaps when idling is on.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            predict_unit(req_code_unit);
            units_sent++;
         end
         if (code_units.size() != 0 && (!idle_on || $urandom_range(99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_code_unit <= code_units.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each beat and paces rsp_ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $error("token beat kind %0d arrived with nothing expected", rsp_kind);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("repeat_res", want.repeat_res, rsp_repeat_res);
               check_field("arg_count", want.arg_count, rsp_arg_count);
               check_field("byte_count", want.byte_count, rsp_byte_count);
               check_field("last", want.last, rsp_last);
            end
            results_checked++;
         end
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Test sequence: directed lines, then random phases at each byte width.
   initial begin
      restart_line();
      unit_bytes = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_units[i]) queue_unit(opening_units[i]);
      settle();

      // Receiver holds off while the sender keeps offering code units.
      set_bytes_per_char(2'd2);
      fill_random(45);
      hold_asks <= hold_asks + 1;
      settle();

      set_bytes_per_char(2'd0);
      fill_random(35);
      settle();

      // The widest byte width that the register can hold.
      set_bytes_per_char(2'd3);
      fill_random(35);
      settle();

      // No idling here.
      set_bytes_per_char(2'd1);
      idle_on <= 1'b0;
      fill_random(45);
      settle();

      $display("Tokenized %0d code units into %0d checked beats, %0d mismatches.",
               units_sent, results_checked, mismatches);
      $display("Byte widths 0 to 3, backslash-quote rules and a long receiver stall.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
